@@ rtl/ukq_pkg.sv @@
// Package for the unique-key move-to-rear queue.
// Holds the sizes, the request and status codes, the sequencer states and the
// store request struct. It depends on nothing else.
package ukq_pkg;

  localparam int StoreDepth = 256;
  localparam int AddrW      = $clog2(StoreDepth);
  localparam int KeyW       = 8;
  localparam int CountW     = AddrW + 1;
  localparam int Capacity   = 256;
  localparam int StatusW    = 3;

  typedef enum logic {
    REQ_ACCESS = 1'b0,
    REQ_REMOVE = 1'b1
  } req_type_e;

  typedef enum logic [StatusW-1:0] {
    ST_INSERTED     = 3'd0,
    ST_ALREADY_REAR = 3'd1,
    ST_MOVED        = 3'd2,
    ST_REMOVED      = 3'd3,
    ST_UNDERFLOW    = 3'd4,
    ST_FULL         = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_POP,
    S_SHIFT,
    S_TAIL
  } state_e;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [KeyW-1:0]  wdata;
    logic [AddrW-1:0] raddr;
  } ram_req_t;

endpackage

@@ rtl/ukq_ram.sv @@
// Key store for the unique-key move-to-rear queue: one write and one
// registered read per cycle. Depends on ukq_pkg.
module ukq_ram (
  input  logic                     clk_i,
  input  ukq_pkg::ram_req_t        req_i,
  output logic [ukq_pkg::KeyW-1:0] rdata_o
);

  logic [ukq_pkg::KeyW-1:0] mem [ukq_pkg::StoreDepth];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_o <= mem[req_i.raddr];
  end

endmodule

@@ rtl/ukq_ctrl.sv @@
// Sequencer of the unique-key move-to-rear queue: walks the key store one
// entry a cycle with a single compare and address unit, for search and gap
// closing. Depends on ukq_pkg.
module ukq_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        req_type_i,
  input  logic [ukq_pkg::KeyW-1:0]    key_i,
  output ukq_pkg::ram_req_t           ram_o,
  input  logic [ukq_pkg::KeyW-1:0]    rdata_i,
  output logic                        done_o,
  output logic [ukq_pkg::StatusW-1:0] status_o,
  output logic [ukq_pkg::KeyW-1:0]    front_key_o,
  output logic [ukq_pkg::CountW-1:0]  occupancy_o
);

  ukq_pkg::state_e              state_q, state_d;
  logic [ukq_pkg::AddrW-1:0]    idx_q, idx_d;
  logic [ukq_pkg::CountW-1:0]   count_q, count_d;
  logic [ukq_pkg::KeyW-1:0]     key_q, key_d;
  logic                         op_q, op_d;
  logic [ukq_pkg::KeyW-1:0]     popped_q, popped_d;
  logic                         done_q, done_d;
  ukq_pkg::status_e             status_q, status_d;
  logic [ukq_pkg::KeyW-1:0]     front_q, front_d;
  logic [ukq_pkg::CountW-1:0]   occ_q, occ_d;
  logic [ukq_pkg::CountW-1:0]   last;
  logic [ukq_pkg::CountW-1:0]   idx_ext;

  assign last    = count_q - ukq_pkg::CountW'(1);
  assign idx_ext = {1'b0, idx_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ukq_pkg::S_IDLE;
      idx_q    <= '0;
      count_q  <= '0;
      key_q    <= '0;
      op_q     <= 1'b0;
      popped_q <= '0;
      done_q   <= 1'b0;
      status_q <= ukq_pkg::ST_INSERTED;
      front_q  <= '0;
      occ_q    <= '0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      count_q  <= count_d;
      key_q    <= key_d;
      op_q     <= op_d;
      popped_q <= popped_d;
      done_q   <= done_d;
      status_q <= status_d;
      front_q  <= front_d;
      occ_q    <= occ_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    count_d   = count_q;
    key_d     = key_q;
    op_d      = op_q;
    popped_d  = popped_q;
    done_d    = 1'b0;
    status_d  = status_q;
    front_d   = front_q;
    occ_d     = occ_q;
    ram_o.we    = 1'b0;
    ram_o.waddr = idx_q;
    ram_o.wdata = rdata_i;
    ram_o.raddr = idx_q + ukq_pkg::AddrW'(1);

    unique case (state_q)
      ukq_pkg::S_IDLE: begin
        ram_o.raddr = '0;
        if (start) begin
          key_d = key_i;
          op_d  = req_type_i;
          idx_d = '0;
          if (req_type_i == ukq_pkg::REQ_REMOVE) begin
            if (count_q == '0) begin
              done_d   = 1'b1;
              status_d = ukq_pkg::ST_UNDERFLOW;
              front_d  = '0;
              occ_d    = '0;
            end else begin
              state_d = ukq_pkg::S_POP;
            end
          end else if (count_q == '0) begin
            // An empty queue needs no search: the key goes straight in.
            ram_o.we    = 1'b1;
            ram_o.waddr = '0;
            ram_o.wdata = key_i;
            count_d     = ukq_pkg::CountW'(1);
            done_d      = 1'b1;
            status_d    = ukq_pkg::ST_INSERTED;
            front_d     = '0;
            occ_d       = ukq_pkg::CountW'(1);
          end else begin
            state_d = ukq_pkg::S_SEARCH;
          end
        end
      end

      ukq_pkg::S_SEARCH: begin
        // The read data belongs to entry idx_q; the next entry is fetched meanwhile.
        if (rdata_i == key_q) begin
          if (idx_ext == last) begin
            state_d  = ukq_pkg::S_IDLE;
            done_d   = 1'b1;
            status_d = ukq_pkg::ST_ALREADY_REAR;
            front_d  = '0;
            occ_d    = count_q;
          end else begin
            state_d = ukq_pkg::S_SHIFT;
          end
        end else if (idx_ext == last) begin
          state_d = ukq_pkg::S_IDLE;
          done_d  = 1'b1;
          front_d = '0;
          if (count_q >= ukq_pkg::CountW'(ukq_pkg::Capacity)) begin
            status_d = ukq_pkg::ST_FULL;
            occ_d    = count_q;
          end else begin
            ram_o.we    = 1'b1;
            ram_o.waddr = count_q[ukq_pkg::AddrW-1:0];
            ram_o.wdata = key_q;
            count_d     = count_q + ukq_pkg::CountW'(1);
            status_d    = ukq_pkg::ST_INSERTED;
            occ_d       = count_q + ukq_pkg::CountW'(1);
          end
        end else begin
          idx_d = idx_q + ukq_pkg::AddrW'(1);
        end
      end

      ukq_pkg::S_POP: begin
        popped_d = rdata_i;
        if (count_q == ukq_pkg::CountW'(1)) begin
          state_d  = ukq_pkg::S_IDLE;
          count_d  = '0;
          done_d   = 1'b1;
          status_d = ukq_pkg::ST_REMOVED;
          front_d  = rdata_i;
          occ_d    = '0;
        end else begin
          state_d = ukq_pkg::S_SHIFT;
        end
      end

      ukq_pkg::S_SHIFT: begin
        // Each entry behind the gap moves down by one place.
        ram_o.we    = 1'b1;
        ram_o.waddr = idx_q;
        ram_o.wdata = rdata_i;
        ram_o.raddr = idx_q + ukq_pkg::AddrW'(2);
        if (idx_ext + ukq_pkg::CountW'(1) == last) begin
          if (op_q == ukq_pkg::REQ_REMOVE) begin
            state_d  = ukq_pkg::S_IDLE;
            count_d  = last;
            done_d   = 1'b1;
            status_d = ukq_pkg::ST_REMOVED;
            front_d  = popped_q;
            occ_d    = last;
          end else begin
            state_d = ukq_pkg::S_TAIL;
          end
        end else begin
          idx_d = idx_q + ukq_pkg::AddrW'(1);
        end
      end

      ukq_pkg::S_TAIL: begin
        ram_o.we    = 1'b1;
        ram_o.waddr = last[ukq_pkg::AddrW-1:0];
        ram_o.wdata = key_q;
        state_d     = ukq_pkg::S_IDLE;
        done_d      = 1'b1;
        status_d    = ukq_pkg::ST_MOVED;
        front_d     = '0;
        occ_d       = count_q;
      end

      default: begin
        state_d = ukq_pkg::S_IDLE;
      end
    endcase
  end

  assign busy        = (state_q != ukq_pkg::S_IDLE);
  assign done_o      = done_q;
  assign status_o    = status_q;
  assign front_key_o = front_q;
  assign occupancy_o = occ_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= ukq_pkg::CountW'(ukq_pkg::Capacity))
    else $error("queue count above capacity");

  a_done_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_q) |-> ($past(state_q) != ukq_pkg::S_IDLE || $past(start)))
    else $error("result without a request");

  a_full_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && status_q == ukq_pkg::ST_FULL) |->
      count_q == ukq_pkg::CountW'(ukq_pkg::Capacity))
    else $error("full status with room left");

  a_underflow_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && status_q == ukq_pkg::ST_UNDERFLOW) |-> (occ_q == '0 && count_q == '0))
    else $error("underflow reported on a non-empty queue");

  a_write_in_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_o.we |-> (state_q != ukq_pkg::S_IDLE || start))
    else $error("store written outside a request");
`endif

endmodule

@@ rtl/unique_key_move_to_rear_queue.sv @@
// Top level of the unique-key move-to-rear queue (a recency list of keys).
// Instantiates ukq_ctrl and ukq_ram; depends on ukq_pkg.
//
// Usage:
//   A request (req_type_i, key_i) is taken at a rising edge where start is
//   high and busy is low. req_type_i selects access (search, then append or
//   move the key to the rear) or remove (pop the front key).
//   Exactly one result follows each request: status_o, front_key_o and
//   occupancy_o are valid for the single cycle in which done_o is high.
//   The receiver cannot stall, so results are never held back.
// Sequence:
//   An access to, or a remove from, an empty queue is answered from idle;
//   an access searches from the front until the key or the last entry is
//   found, then reports a key already at the rear, appends an absent key
//   (or reports full), or closes the gap and writes the key at the rear; a
//   remove reads the front and the rest closes up one entry per cycle.
//   busy falls in the result cycle, so the next request can be taken at the
//   edge that ends it.
// Reset:
//   rst_ni clears the queue to empty; the store itself is not cleared.
module unique_key_move_to_rear_queue (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        req_type_i,
  input  logic [ukq_pkg::KeyW-1:0]    key_i,
  output logic                        done_o,
  output logic [ukq_pkg::StatusW-1:0] status_o,
  output logic [ukq_pkg::KeyW-1:0]    front_key_o,
  output logic [ukq_pkg::CountW-1:0]  occupancy_o
);

  ukq_pkg::ram_req_t        ram_req;
  logic [ukq_pkg::KeyW-1:0] ram_rdata;

  ukq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_type_i  (req_type_i),
    .key_i       (key_i),
    .ram_o       (ram_req),
    .rdata_i     (ram_rdata),
    .done_o      (done_o),
    .status_o    (status_o),
    .front_key_o (front_key_o),
    .occupancy_o (occupancy_o)
  );

  ukq_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

endmodule
